>>> rtl/core/eds_pkg.sv
// Shared types and constants for the event deadline scheduler.
// No dependencies; imported by eds_core and the top level of the block.
`timescale 1ns / 1ps
`default_nettype none

package eds_pkg;

   localparam int MODE_BITS  = 4;
   localparam int CHAN_BITS  = 4;
   localparam int CODE_BITS  = 7;
   localparam int DATA_BITS  = 16;
   localparam int DELAY_BITS = 32;

   // channel that tracks the due times of the two job slots
   localparam int JOB_CHANNEL = 1;

   localparam logic [CODE_BITS-1:0] CODE_PAIR_MASK = 7'h7E;
   localparam logic [CODE_BITS-1:0] CODE_FULL_MASK = 7'h7F;

   typedef logic [MODE_BITS-1:0] mode_type;

   localparam mode_type MODE_TICK       = 4'd0;
   localparam mode_type MODE_SET_ABS    = 4'd1;
   localparam mode_type MODE_SET_REL    = 4'd2;
   localparam mode_type MODE_DEACTIVATE = 4'd3;
   localparam mode_type MODE_QUERY      = 4'd4;
   localparam mode_type MODE_ADD_JOB    = 4'd5;
   localparam mode_type MODE_CANCEL_JOB = 4'd6;
   localparam mode_type MODE_FORCE_JOB  = 4'd7;
   localparam mode_type MODE_CLEAR      = 4'd8;

   // one executed job as carried by a result word
   typedef struct packed {
      logic                 valid;
      logic [CODE_BITS-1:0] code;
      logic [DATA_BITS-1:0] data;
      logic                 early;
   } job_rec_type;

   // pipeline occupancy of the core
   typedef struct packed {
      logic in_busy;
      logic res_valid;
      logic res_two;
   } core_stat_type;

endpackage

`default_nettype wire

>>> rtl/core/eds_min.sv
// Earliest deadline over all channels: balanced compare tree.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module eds_min #(
   parameter int NUM_CHANNELS = 9,
   parameter int TIME_BITS    = 63
) (
   input  wire logic [TIME_BITS-1:0] deadline [NUM_CHANNELS],
   output logic      [TIME_BITS-1:0] earliest
);

   localparam int LEVELS = $clog2(NUM_CHANNELS);
   localparam int LEAVES = 1 << LEVELS;

   logic [TIME_BITS-1:0] node [LEVELS+1][LEAVES];

   always_comb begin
      for (int l = 0; l <= LEVELS; l++) begin
         for (int i = 0; i < LEAVES; i++) begin
            node[l][i] = '1;
         end
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         node[0][i] = deadline[i];
      end
      for (int l = 0; l < LEVELS; l++) begin
         for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
            node[l+1][i] = (node[l][2*i] < node[l][2*i+1]) ? node[l][2*i] : node[l][2*i+1];
         end
      end
   end

   assign earliest = node[LEVELS][0];

endmodule

`default_nettype wire

>>> rtl/core/eds_fifo.sv
// Result queue: two writes and one registered-array read per cycle.
// Generic over width; depth must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module eds_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push_lo,
   input  wire logic                       push_hi,
   input  wire logic [WIDTH-1:0]           wr_lo,
   input  wire logic [WIDTH-1:0]           wr_hi,
   input  wire logic                       pop,
   output logic      [WIDTH-1:0]           rd_data,
   output logic      [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_hi;

   assign wr_ptr_hi = wr_ptr_ff + PTR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_lo) + PTR_W'(push_hi);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff  <= count_ff + CNT_W'(push_lo) + CNT_W'(push_hi) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_lo) begin
         mem_ff[wr_ptr_ff] <= wr_lo;
      end
      if (push_hi) begin
         mem_ff[wr_ptr_hi] <= wr_hi;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign count   = count_ff;

endmodule

`default_nettype wire

>>> rtl/core/eds_core.sv
// Scheduler state and the single-pass update for one request word.
// Depends on eds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eds_core
   import eds_pkg::*;
#(
   parameter int NUM_CHANNELS = 9,
   parameter int TIME_BITS    = 63
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_load,
   input  wire logic [MODE_BITS-1:0]    in_mode,
   input  wire logic [CHAN_BITS-1:0]    in_channel,
   input  wire logic [TIME_BITS-1:0]    in_time,
   input  wire logic [CODE_BITS-1:0]    in_code,
   input  wire logic [DATA_BITS-1:0]    in_data,
   input  wire logic                    in_ptr,
   output core_stat_type                stat,
   output logic      [NUM_CHANNELS-1:0] res_fired,
   output job_rec_type                  res_job0,
   output job_rec_type                  res_job1,
   output logic      [DELAY_BITS-1:0]   res_delay,
   output logic      [TIME_BITS-1:0]    chan_dl [NUM_CHANNELS]
);

   localparam logic [TIME_BITS-1:0] TIME_NONE = '1;
   localparam logic [TIME_BITS-1:0] TIME_LAST = {{(TIME_BITS-1){1'b1}}, 1'b0};

   // input register
   logic                 in_v_ff;
   logic [MODE_BITS-1:0] in_mode_ff;
   logic [CHAN_BITS-1:0] in_chan_ff;
   logic [TIME_BITS-1:0] in_time_ff;
   logic [CODE_BITS-1:0] in_code_ff;
   logic [DATA_BITS-1:0] in_data_ff;
   logic                 in_ptr_ff;

   // scheduler state
   logic [TIME_BITS-1:0] cur_time_ff, cur_time_in;
   logic [TIME_BITS-1:0] chan_dl_ff [NUM_CHANNELS];
   logic [TIME_BITS-1:0] chan_dl_in [NUM_CHANNELS];
   logic [TIME_BITS-1:0] slot_due_ff [2];
   logic [TIME_BITS-1:0] slot_due_in [2];
   logic [CODE_BITS-1:0] slot_job_ff [2];
   logic [CODE_BITS-1:0] slot_job_in [2];
   logic [DATA_BITS-1:0] slot_pay_ff [2];
   logic [DATA_BITS-1:0] slot_pay_in [2];

   // result register
   logic                    res_v_ff, res_two_ff, res_two_in;
   logic [NUM_CHANNELS-1:0] res_fired_ff, res_fired_in;
   job_rec_type             res_job0_ff, res_job0_in;
   job_rec_type             res_job1_ff, res_job1_in;
   logic [DELAY_BITS-1:0]   res_delay_ff, res_delay_in;

   // shared arithmetic
   logic [TIME_BITS:0]      add_sum;
   logic [TIME_BITS-1:0]    sat_time;
   logic [TIME_BITS-1:0]    tick_time;
   logic                    chan_ok;
   logic [TIME_BITS-1:0]    query_dl;
   logic [TIME_BITS-1:0]    query_diff;
   logic [2*DELAY_BITS-1:0] query_wide;
   logic                    job_live;
   logic                    hit0, hit1;
   logic                    slots_full, add_sel;
   logic                    force_m0, force_m1;
   logic [CODE_BITS-1:0]    cancel_mask;
   logic                    cancel_m0, cancel_m1;
   logic                    sel;
   logic [TIME_BITS-1:0]    job_dl;

   function automatic job_rec_type make_rec(logic [CODE_BITS-1:0] code,
                                            logic [DATA_BITS-1:0] data,
                                            logic early);
      job_rec_type r;
      r.valid = 1'b1;
      r.code  = code;
      r.data  = data;
      r.early = early;
      return r;
   endfunction

   // clock + value, saturating at the inactive code
   assign add_sum  = {1'b0, cur_time_ff} + {1'b0, in_time_ff};
   assign sat_time = add_sum[TIME_BITS] ? TIME_NONE : add_sum[TIME_BITS-1:0];

   // clock stops one short of inactive
   assign tick_time = (cur_time_ff < TIME_LAST) ? cur_time_ff + TIME_BITS'(1) : cur_time_ff;

   assign chan_ok = 32'(in_chan_ff) < NUM_CHANNELS;

   always_comb begin
      query_dl = TIME_NONE;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (32'(in_chan_ff) == c) begin
            query_dl = chan_dl_ff[c];
         end
      end
   end

   assign query_diff = query_dl - cur_time_ff;
   assign query_wide = (2*DELAY_BITS)'(query_diff);

   assign job_live = chan_dl_ff[JOB_CHANNEL] != TIME_NONE;
   assign hit0     = slot_due_ff[0] == tick_time;
   assign hit1     = slot_due_ff[1] == tick_time;

   assign slots_full = (slot_due_ff[0] != TIME_NONE) && (slot_due_ff[1] != TIME_NONE);
   assign add_sel    = (slot_due_ff[0] == TIME_NONE) ? 1'b0 :
                       (slot_due_ff[1] == TIME_NONE) ? 1'b1 :
                       (slot_due_ff[0] <= slot_due_ff[1]) ? 1'b0 : 1'b1;

   assign force_m0 = (slot_job_ff[0] & CODE_PAIR_MASK) == in_code_ff;
   assign force_m1 = (slot_job_ff[1] & CODE_PAIR_MASK) == in_code_ff;

   assign cancel_mask = in_ptr_ff ? CODE_PAIR_MASK : CODE_FULL_MASK;
   assign cancel_m0   = (slot_job_ff[0] & cancel_mask) == in_code_ff;
   assign cancel_m1   = (slot_job_ff[1] & cancel_mask) == in_code_ff;

   always_comb begin
      cur_time_in  = cur_time_ff;
      chan_dl_in   = chan_dl_ff;
      slot_due_in  = slot_due_ff;
      slot_job_in  = slot_job_ff;
      slot_pay_in  = slot_pay_ff;
      res_fired_in = '0;
      res_job0_in  = '0;
      res_job1_in  = '0;
      res_two_in   = 1'b0;
      res_delay_in = '0;
      sel          = add_sel;
      job_dl       = chan_dl_ff[JOB_CHANNEL];
      if (in_v_ff) begin
         unique case (in_mode_ff) inside
            MODE_TICK: begin
               cur_time_in = tick_time;
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  if (chan_dl_ff[c] == tick_time) begin
                     res_fired_in[c] = 1'b1;
                     chan_dl_in[c]   = TIME_NONE;
                  end
               end
               if (res_fired_in[JOB_CHANNEL]) begin
                  if (hit0) begin
                     res_job0_in    = make_rec(slot_job_ff[0], slot_pay_ff[0], 1'b0);
                     slot_due_in[0] = TIME_NONE;
                     slot_job_in[0] = '0;
                     slot_pay_in[0] = '0;
                  end
                  if (hit1) begin
                     if (hit0) begin
                        res_job1_in = make_rec(slot_job_ff[1], slot_pay_ff[1], 1'b0);
                        res_two_in  = 1'b1;
                     end else begin
                        res_job0_in = make_rec(slot_job_ff[1], slot_pay_ff[1], 1'b0);
                     end
                     slot_due_in[1] = TIME_NONE;
                     slot_job_in[1] = '0;
                     slot_pay_in[1] = '0;
                  end
                  chan_dl_in[JOB_CHANNEL] = (slot_due_in[0] < slot_due_in[1]) ?
                                            slot_due_in[0] : slot_due_in[1];
               end
            end
            MODE_SET_ABS, MODE_SET_REL: begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  if (32'(in_chan_ff) == c) begin
                     chan_dl_in[c] = (in_mode_ff == MODE_SET_ABS) ? in_time_ff : sat_time;
                  end
               end
            end
            MODE_DEACTIVATE: begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  if (32'(in_chan_ff) == c) begin
                     chan_dl_in[c] = TIME_NONE;
                  end
               end
            end
            MODE_QUERY: begin
               if (chan_ok && (query_dl > cur_time_ff)) begin
                  res_delay_in = (|query_wide[2*DELAY_BITS-1:DELAY_BITS]) ?
                                 '1 : query_wide[DELAY_BITS-1:0];
               end
            end
            MODE_ADD_JOB: begin
               // both slots taken: the earlier job goes out now
               if (slots_full) begin
                  res_job0_in = make_rec(slot_job_ff[sel], slot_pay_ff[sel], 1'b1);
                  job_dl      = slot_due_ff[~sel];
               end
               slot_due_in[sel] = sat_time;
               slot_job_in[sel] = in_code_ff;
               slot_pay_in[sel] = in_data_ff;
               chan_dl_in[JOB_CHANNEL] = (sat_time < job_dl) ? sat_time : job_dl;
            end
            MODE_CANCEL_JOB: begin
               if (job_live) begin
                  if (cancel_m0) begin
                     slot_due_in[0]          = TIME_NONE;
                     chan_dl_in[JOB_CHANNEL] = slot_due_ff[1];
                  end else if (cancel_m1) begin
                     slot_due_in[1]          = TIME_NONE;
                     chan_dl_in[JOB_CHANNEL] = slot_due_ff[0];
                  end
               end
            end
            MODE_FORCE_JOB: begin
               sel = !force_m0;
               if (job_live && (force_m0 || force_m1)) begin
                  res_job0_in             = make_rec(slot_job_ff[sel], slot_pay_ff[sel], 1'b0);
                  slot_due_in[sel]        = TIME_NONE;
                  slot_job_in[sel]        = '0;
                  slot_pay_in[sel]        = '0;
                  chan_dl_in[JOB_CHANNEL] = slot_due_ff[~sel];
               end
            end
            MODE_CLEAR: begin
               cur_time_in = '0;
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  chan_dl_in[c] = TIME_NONE;
               end
               for (int k = 0; k < 2; k++) begin
                  slot_due_in[k] = TIME_NONE;
                  slot_job_in[k] = '0;
                  slot_pay_in[k] = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff     <= 1'b0;
         res_v_ff    <= 1'b0;
         res_two_ff  <= 1'b0;
         cur_time_ff <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            chan_dl_ff[c] <= TIME_NONE;
         end
         for (int k = 0; k < 2; k++) begin
            slot_due_ff[k] <= TIME_NONE;
            slot_job_ff[k] <= '0;
            slot_pay_ff[k] <= '0;
         end
      end else begin
         in_v_ff     <= in_load;
         res_v_ff    <= in_v_ff;
         res_two_ff  <= in_v_ff & res_two_in;
         cur_time_ff <= cur_time_in;
         chan_dl_ff  <= chan_dl_in;
         slot_due_ff <= slot_due_in;
         slot_job_ff <= slot_job_in;
         slot_pay_ff <= slot_pay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_mode_ff <= in_mode;
         in_chan_ff <= in_channel;
         in_time_ff <= in_time;
         in_code_ff <= in_code;
         in_data_ff <= in_data;
         in_ptr_ff  <= in_ptr;
      end
      res_fired_ff <= res_fired_in;
      res_job0_ff  <= res_job0_in;
      res_job1_ff  <= res_job1_in;
      res_delay_ff <= res_delay_in;
   end

   assign stat.in_busy   = in_v_ff;
   assign stat.res_valid = res_v_ff;
   assign stat.res_two   = res_two_ff;
   assign res_fired      = res_fired_ff;
   assign res_job0       = res_job0_ff;
   assign res_job1       = res_job1_ff;
   assign res_delay      = res_delay_ff;
   assign chan_dl        = chan_dl_ff;

endmodule

`default_nettype wire

>>> rtl/core/event_deadline_scheduler_top.sv
// Event deadline scheduler, top level: request register, core, result queue.
// Depends on eds_pkg, eds_core, eds_min and eds_fifo.
//
// Usage:
//  - req_* carries one request word (tick, set, deactivate, query, add, cancel,
//    force or clear). It is taken at a clock edge with req_valid high and
//    req_stall low.
//  - rsp_* returns the result words in order. A word is taken at an edge with
//    rsp_valid high and rsp_stall low. rsp_last marks the final word of a
//    request; a tick that runs both job slots yields two words, every other
//    request yields one.
//  - Path: a taken request passes the input register, which loads at the
//    edge that takes it, then the update register, then the queue, whose
//    head is shown as the first result word.
//  - Throughput: one request per cycle while results are drained; the
//    update is one pass of compare and add logic, and the earliest deadline
//    comes from a compare tree over the channel registers in the next cycle.
//  - Stall: results collect in an eight-word queue. req_stall rises while
//    the queue plus the words still in flight could not absorb two more, so
//    nothing is ever dropped; a stalled result word holds steady.
//  - Reset (synchronous, active high) empties the pipeline and the queue,
//    sets the clock to zero, retires every channel and empties both slots.
`timescale 1ns / 1ps
`default_nettype none

module event_deadline_scheduler_top
   import eds_pkg::*;
#(
   parameter int NUM_CHANNELS = 9,
   parameter int TIME_BITS    = 63
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [MODE_BITS-1:0]    req_mode,
   input  wire logic [CHAN_BITS-1:0]    req_channel,
   input  wire logic [TIME_BITS-1:0]    req_time_value,
   input  wire logic [CODE_BITS-1:0]    req_job_code,
   input  wire logic [DATA_BITS-1:0]    req_job_data,
   input  wire logic                    req_pointer_match,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic      [NUM_CHANNELS-1:0] rsp_fired_mask,
   output logic                         rsp_job_valid,
   output logic      [CODE_BITS-1:0]    rsp_job_code_out,
   output logic      [DATA_BITS-1:0]    rsp_job_data_out,
   output logic                         rsp_job_early,
   output logic      [DELAY_BITS-1:0]   rsp_delay_out,
   output logic      [TIME_BITS-1:0]    rsp_next_deadline,
   output logic                         rsp_last
);

   localparam int FIFO_DEPTH = 8;
   localparam int CNT_W      = $clog2(FIFO_DEPTH+1);
   localparam int ENTRY_W    = NUM_CHANNELS + 1 + CODE_BITS + DATA_BITS + 1
                               + DELAY_BITS + TIME_BITS + 1;

   core_stat_type           stat;
   logic [NUM_CHANNELS-1:0] res_fired;
   job_rec_type             res_job0, res_job1;
   logic [DELAY_BITS-1:0]   res_delay;
   logic [TIME_BITS-1:0]    chan_dl [NUM_CHANNELS];
   logic [TIME_BITS-1:0]    earliest;
   logic [ENTRY_W-1:0]      entry_lo, entry_hi, head;
   logic [CNT_W-1:0]        fifo_cnt;
   logic [CNT_W:0]          occupancy;
   logic                    req_take;
   logic                    rsp_take;

   // worst case: every word in flight turns into two result words
   assign occupancy = (CNT_W+1)'(fifo_cnt)
                    + (CNT_W+1)'({stat.in_busy, 1'b0})
                    + (CNT_W+1)'({stat.res_valid, 1'b0});
   assign req_stall = occupancy > (CNT_W+1)'(FIFO_DEPTH - 2);
   assign req_take  = req_valid && !req_stall;

   eds_core #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .TIME_BITS    (TIME_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .in_load    (req_take),
      .in_mode    (req_mode),
      .in_channel (req_channel),
      .in_time    (req_time_value),
      .in_code    (req_job_code),
      .in_data    (req_job_data),
      .in_ptr     (req_pointer_match),
      .stat       (stat),
      .res_fired  (res_fired),
      .res_job0   (res_job0),
      .res_job1   (res_job1),
      .res_delay  (res_delay),
      .chan_dl    (chan_dl)
   );

   // channel registers already hold the state left by the word in the result stage
   eds_min #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .TIME_BITS    (TIME_BITS)
   ) u_min (
      .deadline (chan_dl),
      .earliest (earliest)
   );

   assign entry_lo = {res_fired, res_job0.valid, res_job0.code, res_job0.data,
                      res_job0.early, res_delay, earliest, !stat.res_two};
   assign entry_hi = {res_fired, res_job1.valid, res_job1.code, res_job1.data,
                      res_job1.early, {DELAY_BITS{1'b0}}, earliest, 1'b1};

   assign rsp_take = rsp_valid && !rsp_stall;

   eds_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_lo (stat.res_valid),
      .push_hi (stat.res_valid && stat.res_two),
      .wr_lo   (entry_lo),
      .wr_hi   (entry_hi),
      .pop     (rsp_take),
      .rd_data (head),
      .count   (fifo_cnt)
   );

   assign rsp_valid = fifo_cnt != '0;
   assign {rsp_fired_mask, rsp_job_valid, rsp_job_code_out, rsp_job_data_out,
           rsp_job_early, rsp_delay_out, rsp_next_deadline, rsp_last} = head;

   // queue never overruns given the stall margin
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   // a second result word only comes with a first
   a_two_needs_one: assert property (@(posedge clock) disable iff (reset)
      stat.res_two |-> stat.res_valid)
      else $error("second result without first");

   // a taken request reaches the update stage next cycle
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      req_take |=> stat.in_busy)
      else $error("taken request lost");

   // the update stage never holds a word back
   a_core_flows: assert property (@(posedge clock) disable iff (reset)
      stat.in_busy |=> stat.res_valid)
      else $error("core result lost");

endmodule

`default_nettype wire

>>> tb/sv/eds_watch.sv
// Result checker for the event deadline scheduler: predicts every result word
// from the accepted requests and compares them with what the block returns.
// Depends on eds_pkg only; instantiated beside the block by tb_top.
`timescale 1ns / 1ps

module eds_watch
   import eds_pkg::*;
#(
   parameter int NUM_CHANNELS = 9,
   parameter int TIME_BITS    = 63
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_stall,
   input  wire logic [MODE_BITS-1:0]    req_mode,
   input  wire logic [CHAN_BITS-1:0]    req_channel,
   input  wire logic [TIME_BITS-1:0]    req_time_value,
   input  wire logic [CODE_BITS-1:0]    req_job_code,
   input  wire logic [DATA_BITS-1:0]    req_job_data,
   input  wire logic                    req_pointer_match,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire logic [NUM_CHANNELS-1:0] rsp_fired_mask,
   input  wire logic                    rsp_job_valid,
   input  wire logic [CODE_BITS-1:0]    rsp_job_code_out,
   input  wire logic [DATA_BITS-1:0]    rsp_job_data_out,
   input  wire logic                    rsp_job_early,
   input  wire logic [DELAY_BITS-1:0]   rsp_delay_out,
   input  wire logic [TIME_BITS-1:0]    rsp_next_deadline,
   input  wire logic                    rsp_last,
   output int                           fail_count,
   output int                           words_open,
   output int                           words_seen,
   output int                           job_words
);

   typedef logic [TIME_BITS-1:0] tick_t;

   localparam tick_t                 NEVER     = '1;
   localparam logic [DELAY_BITS-1:0] DELAY_CAP = '1;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0] fired;
      logic                    job_valid;
      logic [CODE_BITS-1:0]    code;
      logic [DATA_BITS-1:0]    data;
      logic                    early;
      logic [DELAY_BITS-1:0]   delay;
      tick_t                   soonest;
      logic                    last;
   } sched_word_t;

   sched_word_t          sched_results_q[$];
   tick_t                now_t;
   tick_t                deadline[NUM_CHANNELS];
   tick_t                slot_due[2];
   logic [CODE_BITS-1:0] slot_code[2];
   logic [DATA_BITS-1:0] slot_data[2];

   initial begin
      fail_count = 0;
      words_open = 0;
      words_seen = 0;
      job_words  = 0;
   end

   function automatic tick_t sat_sum(tick_t a, tick_t b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, NEVER}) ? NEVER : s[TIME_BITS-1:0];
   endfunction

   task automatic clear_state();
      now_t = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) deadline[c] = NEVER;
      for (int k = 0; k < 2; k++) begin
         slot_due[k]  = NEVER;
         slot_code[k] = '0;
         slot_data[k] = '0;
      end
   endtask

   // emptying a slot hands the job channel to the other slot's due time
   task automatic release_slot(int s);
      slot_due[s]  = NEVER;
      slot_code[s] = '0;
      slot_data[s] = '0;
      deadline[JOB_CHANNEL] = slot_due[1-s];
   endtask

   function automatic sched_word_t job_word(logic [NUM_CHANNELS-1:0] fired, int s,
                                           logic early, logic [DELAY_BITS-1:0] delay);
      sched_word_t w;
      w           = '0;
      w.fired     = fired;
      w.delay     = delay;
      if (s >= 0) begin
         w.job_valid = 1'b1;
         w.code      = slot_code[s];
         w.data      = slot_data[s];
         w.early     = early;
      end
      return w;
   endfunction

   task automatic schedule_step(mode_type mode, logic [CHAN_BITS-1:0] ch, tick_t tv,
                                logic [CODE_BITS-1:0] code, logic [DATA_BITS-1:0] data,
                                logic ptr);
      sched_word_t             w[2];
      int                      n;
      int                      s;
      logic [NUM_CHANNELS-1:0] fired;
      logic [DELAY_BITS-1:0]   delay;
      logic [CODE_BITS-1:0]    m;
      logic                    chok;
      tick_t                   due;
      tick_t                   low;
      n     = 0;
      s     = -1;
      fired = '0;
      delay = '0;
      chok  = (ch < NUM_CHANNELS);
      case (mode)
         MODE_TICK: begin
            if (now_t < NEVER - 1) now_t = now_t + 1;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (deadline[c] == now_t) begin
                  fired[c]    = 1'b1;
                  deadline[c] = NEVER;
               end
            end
            if (fired[JOB_CHANNEL]) begin
               for (int k = 0; k < 2; k++) begin
                  if (slot_due[k] == now_t) begin
                     w[n] = job_word(fired, k, 1'b0, '0);
                     release_slot(k);
                     n++;
                  end
               end
               deadline[JOB_CHANNEL] = (slot_due[0] < slot_due[1]) ? slot_due[0] : slot_due[1];
            end
            if (n == 0) begin
               w[0] = job_word(fired, -1, 1'b0, '0);
               n    = 1;
            end
         end
         MODE_ADD_JOB: begin
            if (slot_due[0] == NEVER) begin
               s = 0;
            end else if (slot_due[1] == NEVER) begin
               s = 1;
            end else begin
               // both full: the earlier job (slot 0 on a tie) goes out early
               s    = (slot_due[0] <= slot_due[1]) ? 0 : 1;
               w[n] = job_word('0, s, 1'b1, '0);
               n++;
               release_slot(s);
            end
            due          = sat_sum(now_t, tv);
            slot_code[s] = code;
            slot_data[s] = data;
            if (due < deadline[JOB_CHANNEL]) deadline[JOB_CHANNEL] = due;
            slot_due[s] = due;
            if (n == 0) begin
               w[0] = job_word('0, -1, 1'b0, '0);
               n    = 1;
            end
         end
         MODE_FORCE_JOB: begin
            if (deadline[JOB_CHANNEL] != NEVER) begin
               if ((slot_code[0] & CODE_PAIR_MASK) == code) s = 0;
               else if ((slot_code[1] & CODE_PAIR_MASK) == code) s = 1;
            end
            w[0] = job_word('0, s, 1'b0, '0);
            if (s >= 0) release_slot(s);
            n = 1;
         end
         default: begin
            if ((mode == MODE_SET_ABS || mode == MODE_SET_REL) && chok) begin
               deadline[ch] = (mode == MODE_SET_ABS) ? tv : sat_sum(now_t, tv);
            end else if (mode == MODE_DEACTIVATE && chok) begin
               deadline[ch] = NEVER;
            end else if (mode == MODE_QUERY && chok) begin
               if (deadline[ch] > now_t) begin
                  low   = deadline[ch] - now_t;
                  delay = (low > tick_t'(DELAY_CAP)) ? DELAY_CAP : low[DELAY_BITS-1:0];
               end
            end else if (mode == MODE_CANCEL_JOB) begin
               // cancel only empties the due time; code and data stay behind
               if (deadline[JOB_CHANNEL] != NEVER) begin
                  m = ptr ? CODE_PAIR_MASK : CODE_FULL_MASK;
                  if ((slot_code[0] & m) == code) begin
                     slot_due[0]           = NEVER;
                     deadline[JOB_CHANNEL] = slot_due[1];
                  end else if ((slot_code[1] & m) == code) begin
                     slot_due[1]           = NEVER;
                     deadline[JOB_CHANNEL] = slot_due[0];
                  end
               end
            end else if (mode == MODE_CLEAR) begin
               clear_state();
            end
            w[0] = job_word('0, -1, 1'b0, delay);
            n    = 1;
         end
      endcase
      low = NEVER;
      for (int c = 0; c < NUM_CHANNELS; c++)
         if (deadline[c] < low) low = deadline[c];
      for (int k = 0; k < n; k++) begin
         w[k].soonest = low;
         w[k].last    = (k == n - 1);
         sched_results_q.push_back(w[k]);
      end
   endtask

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      sched_word_t want;
      if (reset) begin
         clear_state();
         sched_results_q.delete();
      end else begin
         if (req_valid && !req_stall)
            schedule_step(mode_type'(req_mode), req_channel, req_time_value, req_job_code,
                          req_job_data, req_pointer_match);
         if (rsp_valid && !rsp_stall) begin
            if (sched_results_q.size() == 0) begin
               $error("result word with nothing outstanding");
               fail_count++;
            end else begin
               want = sched_results_q.pop_front();
               check_field("fired_mask",    want.fired,     rsp_fired_mask);
               check_field("job_valid",     want.job_valid, rsp_job_valid);
               check_field("job_code_out",  want.code,      rsp_job_code_out);
               check_field("job_data_out",  want.data,      rsp_job_data_out);
               check_field("job_early",     want.early,     rsp_job_early);
               check_field("delay_out",     want.delay,     rsp_delay_out);
               check_field("next_deadline", want.soonest,   rsp_next_deadline);
               check_field("last",          want.last,      rsp_last);
               words_seen++;
               if (want.job_valid) job_words++;
            end
         end
      end
      words_open = sched_results_q.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the event deadline scheduler: clock, reset, request and
// result-side stall stimulus, verdict. Depends on eds_pkg, eds_watch and the
// block's top level.
`timescale 1ns / 1ps

module tb_top;
   import eds_pkg::*;

   localparam int N_CHAN = 9;
   localparam int T_BITS = 63;

   typedef logic [T_BITS-1:0] tick_t;

   localparam tick_t NEVER        = '1;
   localparam int    HOLD_CYCLES  = 200;   // long receiver hold-off
   localparam int    RANDOM_WORDS = 1300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [MODE_BITS-1:0]  req_mode = '0;
   logic [CHAN_BITS-1:0]  req_channel = '0;
   tick_t                 req_time_value = '0;
   logic [CODE_BITS-1:0]  req_job_code = '0;
   logic [DATA_BITS-1:0]  req_job_data = '0;
   logic                  req_pointer_match = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [N_CHAN-1:0]     rsp_fired_mask;
   logic                  rsp_job_valid;
   logic [CODE_BITS-1:0]  rsp_job_code_out;
   logic [DATA_BITS-1:0]  rsp_job_data_out;
   logic                  rsp_job_early;
   logic [DELAY_BITS-1:0] rsp_delay_out;
   tick_t                 rsp_next_deadline;
   logic                  rsp_last;

   int fail_count;
   int words_open;
   int words_seen;
   int job_words;

   // stimulus-side bookkeeping
   logic                 hold_req = 1'b0;  // asks the result side for the long hold-off
   logic                 no_gaps  = 1'b0;  // sender offers back to back
   int                   burst_left = 0;
   int                   ticks_since_clear = 0;
   int                   mode_hits[16];
   int                   words_sent = 0;
   logic [CODE_BITS-1:0] recent_code[2];
   int                   recent_idx = 0;

   event_deadline_scheduler_top #(
      .NUM_CHANNELS (N_CHAN),
      .TIME_BITS    (T_BITS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_channel       (req_channel),
      .req_time_value    (req_time_value),
      .req_job_code      (req_job_code),
      .req_job_data      (req_job_data),
      .req_pointer_match (req_pointer_match),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fired_mask    (rsp_fired_mask),
      .rsp_job_valid     (rsp_job_valid),
      .rsp_job_code_out  (rsp_job_code_out),
      .rsp_job_data_out  (rsp_job_data_out),
      .rsp_job_early     (rsp_job_early),
      .rsp_delay_out     (rsp_delay_out),
      .rsp_next_deadline (rsp_next_deadline),
      .rsp_last          (rsp_last)
   );

   eds_watch #(
      .NUM_CHANNELS (N_CHAN),
      .TIME_BITS    (T_BITS)
   ) u_watch (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_channel       (req_channel),
      .req_time_value    (req_time_value),
      .req_job_code      (req_job_code),
      .req_job_data      (req_job_data),
      .req_pointer_match (req_pointer_match),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fired_mask    (rsp_fired_mask),
      .rsp_job_valid     (rsp_job_valid),
      .rsp_job_code_out  (rsp_job_code_out),
      .rsp_job_data_out  (rsp_job_data_out),
      .rsp_job_early     (rsp_job_early),
      .rsp_delay_out     (rsp_delay_out),
      .rsp_next_deadline (rsp_next_deadline),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .words_open        (words_open),
      .words_seen        (words_seen),
      .job_words         (job_words)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Safety net: a time limit well above the slowest legal run.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Sender idle time: back-to-back bursts, short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
         burst_left = $urandom_range(5, 40);
         return 0;
      end
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic tick_t any_time();
      return tick_t'({$urandom(), $urandom()});
   endfunction

   // Offer one request word and hold it until the block takes it.
   // valid stays high into the next word unless a gap is picked.
   task automatic send_word(mode_type mode, logic [CHAN_BITS-1:0] ch, tick_t tv,
                            logic [CODE_BITS-1:0] code, logic [DATA_BITS-1:0] data,
                            logic ptr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_channel       <= ch;
      req_time_value    <= tv;
      req_job_code      <= code;
      req_job_data      <= data;
      req_pointer_match <= ptr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      mode_hits[mode]++;
      if (mode == MODE_TICK) ticks_since_clear++;
      if (mode == MODE_CLEAR) ticks_since_clear = 0;
      if (mode == MODE_ADD_JOB) begin
         recent_code[recent_idx] = code;
         recent_idx              = 1 - recent_idx;
      end
   endtask

   // Sender pause: nothing more is offered until every word is back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_open != 0) @(posedge clock);
   endtask

   // One random request. Mostly ticks and near-term deadlines and jobs so
   // that channels fire and slots run; clears keep the clock small.
   task automatic random_word();
      int                   r;
      mode_type             mode;
      logic [CHAN_BITS-1:0] ch;
      tick_t                tv;
      logic [CODE_BITS-1:0] code;
      logic                 ptr;
      r = $urandom_range(0, 99);
      if (r < 36)      mode = MODE_TICK;
      else if (r < 46) mode = MODE_SET_ABS;
      else if (r < 56) mode = MODE_SET_REL;
      else if (r < 61) mode = MODE_DEACTIVATE;
      else if (r < 70) mode = MODE_QUERY;
      else if (r < 82) mode = MODE_ADD_JOB;
      else if (r < 89) mode = MODE_CANCEL_JOB;
      else if (r < 95) mode = MODE_FORCE_JOB;
      else if (r < 97) mode = MODE_CLEAR;
      else             mode = mode_type'(MODE_CLEAR + $urandom_range(1, 7));  // unused codes

      ch  = ($urandom_range(0, 9) == 0) ? CHAN_BITS'($urandom_range(N_CHAN, 15))
                                        : CHAN_BITS'($urandom_range(0, N_CHAN - 1));
      ptr = 1'($urandom_range(0, 1));

      r = $urandom_range(0, 99);
      if (mode == MODE_SET_ABS) begin
         if (r < 70)      tv = tick_t'(ticks_since_clear + $urandom_range(0, 8));
         else if (r < 80) tv = tick_t'($urandom_range(0, ticks_since_clear));
         else if (r < 90) tv = any_time();
         else             tv = NEVER - tick_t'($urandom_range(0, 1));
      end else if (mode == MODE_SET_REL || mode == MODE_ADD_JOB) begin
         if (r < 75)      tv = tick_t'($urandom_range(0, 10));
         else if (r < 90) tv = any_time();
         else             tv = NEVER - tick_t'($urandom_range(0, 3));
      end else begin
         tv = any_time();
      end

      // aim cancel and force at the jobs just added most of the time
      code = CODE_BITS'($urandom());
      if ($urandom_range(0, 99) < 65) begin
         code = recent_code[$urandom_range(0, 1)];
         if (mode == MODE_FORCE_JOB || (mode == MODE_CANCEL_JOB && ptr))
            code = code & CODE_PAIR_MASK;
      end
      send_word(mode, ch, tv, code, DATA_BITS'($urandom()), ptr);
   endtask

   // Result side: random stall pattern plus one long hold-off on request.
   initial begin : rsp_side
      int   stall_left;
      int   run_left;
      int   r;
      logic hold_taken;
      logic stall_now;
      stall_left = 0;
      run_left   = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_taken) begin
            stall_left = HOLD_CYCLES;
            run_left   = 0;
            hold_taken = 1'b1;
         end
         if (!hold_req) hold_taken = 1'b0;
         if (stall_left > 0) begin
            stall_now = 1'b1;
            stall_left--;
         end else if (run_left > 0) begin
            stall_now = 1'b0;
            run_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               stall_now = 1'b0;
               run_left  = $urandom_range(3, 40);
            end else if (r < 90) begin
               stall_now  = 1'b1;
               stall_left = $urandom_range(0, 2);
            end else begin
               stall_now  = 1'b1;
               stall_left = $urandom_range(10, 50);
            end
         end
         rsp_stall <= stall_now;
      end
   end

   initial begin : stimulus
      foreach (mode_hits[i]) mode_hits[i] = 0;
      recent_code[0] = '0;
      recent_code[1] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      send_word(MODE_TICK,       4'd0,  '0,                 '0,    '0,       1'b0); // idle tick
      send_word(MODE_QUERY,      4'd0,  '0,                 '0,    '0,       1'b0); // inactive: capped
      send_word(MODE_SET_ABS,    4'd0,  tick_t'(3),         '0,    '0,       1'b0);
      send_word(MODE_SET_REL,    4'd8,  tick_t'(1),         '0,    '0,       1'b0);
      send_word(MODE_SET_ABS,    4'd12, tick_t'(5),         '1,    '1,       1'b1); // bad channel
      send_word(MODE_QUERY,      4'd15, '1,                 '0,    '0,       1'b0); // bad channel
      send_word(MODE_TICK,       4'd0,  '0,                 '0,    '0,       1'b0); // channel 8 fires
      send_word(MODE_TICK,       4'd0,  '0,                 '0,    '0,       1'b0); // channel 0 fires
      send_word(MODE_SET_ABS,    4'd3,  NEVER - 1,          '0,    '0,       1'b0);
      send_word(MODE_QUERY,      4'd3,  '0,                 '0,    '0,       1'b0); // saturates
      send_word(MODE_SET_REL,    4'd4,  NEVER,              '0,    '0,       1'b0); // sum saturates
      send_word(MODE_SET_ABS,    4'd5,  tick_t'(1),         '0,    '0,       1'b0); // in the past
      send_word(MODE_QUERY,      4'd5,  '0,                 '0,    '0,       1'b0);
      send_word(MODE_DEACTIVATE, 4'd3,  '0,                 '0,    '0,       1'b0);
      send_word(MODE_DEACTIVATE, 4'd15, '0,                 '0,    '0,       1'b0);
      send_word(MODE_CANCEL_JOB, 4'd0,  '0,                 '0,    '0,       1'b0); // no job pending
      send_word(MODE_ADD_JOB,    4'd0,  tick_t'(2),         7'h7F, 16'hFFFF, 1'b0);
      send_word(MODE_ADD_JOB,    4'd0,  tick_t'(2),         7'h00, 16'h0000, 1'b0);
      send_word(MODE_ADD_JOB,    4'd0,  tick_t'(5),         7'h2A, 16'h1234, 1'b0); // tie: slot 0 out
      send_word(MODE_ADD_JOB,    4'd0,  NEVER,              7'h03, 16'h5A5A, 1'b0); // evict, job lost
      send_word(MODE_ADD_JOB,    4'd0,  tick_t'(1),         7'h15, 16'hBEEF, 1'b0);
      send_word(MODE_FORCE_JOB,  4'd0,  '0,                 7'h14, '0,       1'b1); // pair match
      send_word(MODE_CANCEL_JOB, 4'd0,  '0,                 7'h2B, '0,       1'b0); // exact miss
      send_word(MODE_CANCEL_JOB, 4'd0,  '0,                 7'h2A, '0,       1'b1); // pointer hit
      send_word(MODE_ADD_JOB,    4'd0,  tick_t'(2),         7'h11, 16'hA5A5, 1'b0);
      send_word(MODE_ADD_JOB,    4'd0,  tick_t'(2),         7'h12, 16'h0F0F, 1'b0);
      send_word(MODE_TICK,       4'd0,  '0,                 '0,    '0,       1'b0);
      send_word(MODE_TICK,       4'd0,  '0,                 '0,    '0,       1'b0); // both slots run
      send_word(mode_type'(4'hF), 4'hF, NEVER,              '1,    '1,       1'b1); // unused mode
      send_word(MODE_CLEAR,      4'd0,  '0,                 '0,    '0,       1'b0);
      drain();

      // ---- random part ----
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == 600) begin
            // receiver holds off while the sender keeps offering, so the
            // result queue fills and the block stalls its input
            hold_req <= 1'b1;
            no_gaps   = 1'b1;
            repeat (40) random_word();
            no_gaps   = 1'b0;
            hold_req <= 1'b0;
         end
         random_word();
         if (i % 250 == 249) drain();
      end

      // ---- wind down ----
      drain();
      repeat (8) @(posedge clock);

      $display("Sent %0d request words: %0d ticks, %0d sets, %0d queries, %0d adds,",
               words_sent, mode_hits[MODE_TICK],
               mode_hits[MODE_SET_ABS] + mode_hits[MODE_SET_REL], mode_hits[MODE_QUERY],
               mode_hits[MODE_ADD_JOB]);
      $display("  %0d cancels, %0d forces, %0d clears; %0d result words checked, %0d with jobs",
               mode_hits[MODE_CANCEL_JOB], mode_hits[MODE_FORCE_JOB], mode_hits[MODE_CLEAR],
               words_seen, job_words);
      if (fail_count == 0 && words_open == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
